### rtl/fpdf_pkg.sv
// Package for the fixed-point decimal formatter: format codes, character
// codes and the control word that travels with each item down the pipeline.
// No dependencies.
`timescale 1ns / 1ps

package fpdf_pkg;

  // Display formats selected by the format register.
  typedef enum logic [1:0] {
    FMT_HUND   = 2'd0,  // unsigned hundredths, ddd.dd
    FMT_THOU   = 2'd1,  // unsigned thousandths, dd.ddd
    FMT_SIGNED = 2'd2,  // signed thousandths, sd.ddd
    FMT_BIN    = 2'd3   // binary 1/256 rounded to hundredths
  } fmt_e;

  // ASCII codes used in the output string.
  localparam logic [7:0] CH_ZERO  = 8'd48;
  localparam logic [7:0] CH_DOT   = 8'd46;
  localparam logic [7:0] CH_STAR  = 8'd42;
  localparam logic [7:0] CH_MINUS = 8'd45;
  localparam logic [7:0] CH_BLANK = 8'd32;

  // Largest value that still fits five decimal digits, plus one.
  localparam int unsigned LimitFive = 100000;
  // Largest signed magnitude that still fits four digits, plus one.
  localparam int unsigned LimitFour = 10000;

  // Width of the value once it is known to be below LimitFive.
  localparam int unsigned NumW = 17;

  // Control word carried alongside the data in every stage.
  typedef struct packed {
    fmt_e fmt;
    logic neg;
    logic ovf;
  } ctrl_t;

  // Turns a decimal digit into its ASCII character.
  function automatic logic [7:0] digit_char(input logic [3:0] d);
    digit_char = CH_ZERO + {4'b0000, d};
  endfunction

endpackage

### rtl/fpdf_scale.sv
// Front end of the formatter: two register stages that bring the raw input
// to a five-digit magnitude, a sign and an overflow flag per format.
// Depends on fpdf_pkg.
`timescale 1ns / 1ps

module fpdf_scale (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  fpdf_pkg::fmt_e                fmt_i,
  input  logic                          in_valid_i,
  output logic                          in_ready_o,
  input  logic [31:0]                   value_i,
  output logic                          out_valid_o,
  input  logic                          out_ready_i,
  output logic [fpdf_pkg::NumW-1:0]     num_o,
  output logic [7:0]                    quot_o,
  output fpdf_pkg::ctrl_t               ctrl_o
);

  // Stage 1 registers.
  logic                      s1_valid_q;
  logic                      s1_ready;
  fpdf_pkg::ctrl_t           s1_ctrl_q, s1_ctrl_d;
  logic [fpdf_pkg::NumW-1:0] s1_num_q, s1_num_d;
  logic [38:0]               s1_prod_q, s1_prod_d;
  logic [31:0]               mag;

  // Stage 2 registers.
  logic                      s2_valid_q;
  logic                      s2_ready;
  fpdf_pkg::ctrl_t           s2_ctrl_q, s2_ctrl_d;
  logic [fpdf_pkg::NumW-1:0] s2_num_q, s2_num_d;
  logic [7:0]                s2_quot_q, s2_quot_d;
  logic [30:0]               bin_num;
  logic [27:0]               recip_prod;

  assign s1_ready   = !s1_valid_q || s2_ready;
  assign s2_ready   = !s2_valid_q || out_ready_i;
  assign in_ready_o = s1_ready;

  // Stage 1: per-format magnitude and range check; format 3 is scaled by 100.
  always_comb begin
    mag             = value_i[31] ? (32'd0 - value_i) : value_i;
    s1_ctrl_d.fmt   = fmt_i;
    s1_ctrl_d.neg   = 1'b0;
    s1_ctrl_d.ovf   = value_i >= 32'(fpdf_pkg::LimitFive);
    s1_num_d        = value_i[fpdf_pkg::NumW-1:0];
    s1_prod_d       = 39'(value_i) * 39'd100 + 39'd128;
    if (fmt_i == fpdf_pkg::FMT_SIGNED) begin
      s1_ctrl_d.neg = value_i[31];
      s1_ctrl_d.ovf = mag >= 32'(fpdf_pkg::LimitFour);
      s1_num_d      = mag[fpdf_pkg::NumW-1:0];
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_valid_q <= 1'b0;
    end else if (s1_ready) begin
      s1_valid_q <= in_valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_valid_i && s1_ready) begin
      s1_ctrl_q <= s1_ctrl_d;
      s1_num_q  <= s1_num_d;
      s1_prod_q <= s1_prod_d;
    end
  end

  // Stage 2: finish the binary rounding, then estimate value / 1000 by a
  // reciprocal that errs at most one low.
  always_comb begin
    bin_num   = s1_prod_q[38:8];
    s2_ctrl_d = s1_ctrl_q;
    s2_num_d  = s1_num_q;
    if (s1_ctrl_q.fmt == fpdf_pkg::FMT_BIN) begin
      s2_ctrl_d.ovf = bin_num >= 31'(fpdf_pkg::LimitFive);
      s2_num_d      = bin_num[fpdf_pkg::NumW-1:0];
    end
    recip_prod = 28'(s2_num_d) * 28'd1048;
    s2_quot_d  = recip_prod[27:20];
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s2_valid_q <= 1'b0;
    end else if (s2_ready) begin
      s2_valid_q <= s1_valid_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (s1_valid_q && s2_ready) begin
      s2_ctrl_q <= s2_ctrl_d;
      s2_num_q  <= s2_num_d;
      s2_quot_q <= s2_quot_d;
    end
  end

  assign out_valid_o = s2_valid_q;
  assign num_o       = s2_num_q;
  assign quot_o      = s2_quot_q;
  assign ctrl_o      = s2_ctrl_q;

  // The most negative signed input can never be shown.
  a_min_signed_ovf: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_valid_i && s1_ready && fmt_i == fpdf_pkg::FMT_SIGNED && value_i == 32'h8000_0000
    |=> s1_ctrl_q.ovf)
    else $error("most negative signed value not flagged");

endmodule

### rtl/fpdf_split.sv
// Digit split of the formatter: two register stages that correct the
// quotient by 1000 and take out the upper three digits.
// Depends on fpdf_pkg.
`timescale 1ns / 1ps

module fpdf_split (
  input  logic                      clk_i,
  input  logic                      rst_ni,
  input  logic                      in_valid_i,
  output logic                      in_ready_o,
  input  logic [fpdf_pkg::NumW-1:0] num_i,
  input  logic [7:0]                quot_i,
  input  fpdf_pkg::ctrl_t           ctrl_i,
  output logic                      out_valid_o,
  input  logic                      out_ready_i,
  output logic [3:0]                dig0_o,
  output logic [3:0]                dig1_o,
  output logic [3:0]                dig2_o,
  output logic [6:0]                rest_o,
  output fpdf_pkg::ctrl_t           ctrl_o
);

  // Stage 3 registers.
  logic            s3_valid_q;
  logic            s3_ready;
  fpdf_pkg::ctrl_t s3_ctrl_q;
  logic [7:0]      s3_quot_q, s3_quot_d;
  logic [9:0]      s3_rem_q, s3_rem_d;
  logic [17:0]     rem_full;

  // Stage 4 registers.
  logic            s4_valid_q;
  logic            s4_ready;
  fpdf_pkg::ctrl_t s4_ctrl_q;
  logic [3:0]      s4_dig0_q, s4_dig0_d;
  logic [3:0]      s4_dig1_q, s4_dig1_d;
  logic [3:0]      s4_dig2_q, s4_dig2_d;
  logic [6:0]      s4_rest_q, s4_rest_d;
  logic [15:0]     q_prod;
  logic [15:0]     r_prod;
  logic [7:0]      dig1_full;
  logic [9:0]      rest_full;

  assign s3_ready   = !s3_valid_q || s4_ready;
  assign s4_ready   = !s4_valid_q || out_ready_i;
  assign in_ready_o = s3_ready;

  // Stage 3: remainder by 1000, with one correction step on the estimate.
  always_comb begin
    rem_full  = 18'(num_i) - 18'(quot_i) * 18'd1000;
    s3_quot_d = quot_i;
    s3_rem_d  = rem_full[9:0];
    if (rem_full[10:0] >= 11'd1000) begin
      s3_quot_d = quot_i + 8'd1;
      s3_rem_d  = 10'(rem_full[10:0] - 11'd1000);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s3_valid_q <= 1'b0;
    end else if (s3_ready) begin
      s3_valid_q <= in_valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_valid_i && s3_ready) begin
      s3_ctrl_q <= ctrl_i;
      s3_quot_q <= s3_quot_d;
      s3_rem_q  <= s3_rem_d;
    end
  end

  // Stage 4: tens and units of the quotient, hundreds of the remainder.
  always_comb begin
    q_prod    = 16'(s3_quot_q) * 16'd205;
    s4_dig0_d = q_prod[14:11];
    dig1_full = s3_quot_q - 8'(s4_dig0_d) * 8'd10;
    s4_dig1_d = dig1_full[3:0];
    r_prod    = 16'(s3_rem_q) * 16'd41;
    s4_dig2_d = r_prod[15:12];
    rest_full = s3_rem_q - 10'(s4_dig2_d) * 10'd100;
    s4_rest_d = rest_full[6:0];
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s4_valid_q <= 1'b0;
    end else if (s4_ready) begin
      s4_valid_q <= s3_valid_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (s3_valid_q && s4_ready) begin
      s4_ctrl_q <= s3_ctrl_q;
      s4_dig0_q <= s4_dig0_d;
      s4_dig1_q <= s4_dig1_d;
      s4_dig2_q <= s4_dig2_d;
      s4_rest_q <= s4_rest_d;
    end
  end

  assign out_valid_o = s4_valid_q;
  assign dig0_o      = s4_dig0_q;
  assign dig1_o      = s4_dig1_q;
  assign dig2_o      = s4_dig2_q;
  assign rest_o      = s4_rest_q;
  assign ctrl_o      = s4_ctrl_q;

  // For an in-range value the corrected quotient and remainder are exact.
  a_split_exact: assert property (@(posedge clk_i) disable iff (!rst_ni)
    s3_valid_q && !s3_ctrl_q.ovf |-> s3_quot_q < 8'd100 && s3_rem_q < 10'd1000)
    else $error("quotient or remainder by 1000 out of range");

endmodule

### rtl/fpdf_render.sv
// Output stage of the formatter: last two digits and the six characters,
// held in the output register until the transfer completes.
// Depends on fpdf_pkg.
`timescale 1ns / 1ps

module fpdf_render (
  input  logic            clk_i,
  input  logic            rst_ni,
  input  logic            in_valid_i,
  output logic            in_ready_o,
  input  logic [3:0]      dig0_i,
  input  logic [3:0]      dig1_i,
  input  logic [3:0]      dig2_i,
  input  logic [6:0]      rest_i,
  input  fpdf_pkg::ctrl_t ctrl_i,
  output logic            out_valid_o,
  input  logic            out_ready_i,
  output logic [47:0]     chars_o
);

  logic        valid_q;
  logic        ready;
  logic [7:0]  char_q [6];
  logic [7:0]  char_d [6];
  logic [15:0] t_prod;
  logic [3:0]  dig3;
  logic [6:0]  dig4_full;
  logic [3:0]  dig4;

  assign ready      = !valid_q || out_ready_i;
  assign in_ready_o = ready;

  // Tens and units of the last two digits.
  always_comb begin
    t_prod    = 16'(rest_i) * 16'd205;
    dig3      = t_prod[14:11];
    dig4_full = rest_i - 7'(dig3) * 7'd10;
    dig4      = dig4_full[3:0];
  end

  // Character assembly per format, with blanking of leading zeros.
  always_comb begin
    char_d[0] = (dig0_i == 4'd0) ? fpdf_pkg::CH_BLANK : fpdf_pkg::digit_char(dig0_i);
    char_d[1] = fpdf_pkg::digit_char(dig1_i);
    char_d[2] = fpdf_pkg::CH_DOT;
    char_d[3] = fpdf_pkg::digit_char(dig2_i);
    char_d[4] = fpdf_pkg::digit_char(dig3);
    char_d[5] = fpdf_pkg::digit_char(dig4);
    unique case (ctrl_i.fmt)
      fpdf_pkg::FMT_HUND, fpdf_pkg::FMT_BIN: begin
        if (ctrl_i.ovf) begin
          char_d[0] = fpdf_pkg::CH_STAR;
          char_d[1] = fpdf_pkg::CH_STAR;
          char_d[2] = fpdf_pkg::CH_STAR;
          char_d[3] = fpdf_pkg::CH_DOT;
          char_d[4] = fpdf_pkg::CH_STAR;
          char_d[5] = fpdf_pkg::CH_STAR;
        end else begin
          if (dig0_i == 4'd0 && dig1_i == 4'd0) begin
            char_d[1] = fpdf_pkg::CH_BLANK;
          end
          char_d[2] = fpdf_pkg::digit_char(dig2_i);
          char_d[3] = fpdf_pkg::CH_DOT;
        end
      end
      fpdf_pkg::FMT_THOU: begin
        if (ctrl_i.ovf) begin
          char_d[0] = fpdf_pkg::CH_STAR;
          char_d[1] = fpdf_pkg::CH_STAR;
          char_d[3] = fpdf_pkg::CH_STAR;
          char_d[4] = fpdf_pkg::CH_STAR;
          char_d[5] = fpdf_pkg::CH_STAR;
        end
      end
      fpdf_pkg::FMT_SIGNED: begin
        char_d[0] = ctrl_i.neg ? fpdf_pkg::CH_MINUS : fpdf_pkg::CH_BLANK;
        if (ctrl_i.ovf) begin
          char_d[0] = fpdf_pkg::CH_BLANK;
          char_d[1] = fpdf_pkg::CH_STAR;
          char_d[3] = fpdf_pkg::CH_STAR;
          char_d[4] = fpdf_pkg::CH_STAR;
          char_d[5] = fpdf_pkg::CH_STAR;
        end
      end
      default: begin
        char_d[0] = fpdf_pkg::CH_STAR;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else if (ready) begin
      valid_q <= in_valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_valid_i && ready) begin
      char_q <= char_d;
    end
  end

  assign out_valid_o = valid_q;
  assign chars_o     = {char_q[5], char_q[4], char_q[3], char_q[2], char_q[1], char_q[0]};

  // The decimal point sits in a fixed place for each format.
  a_dot_hund: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_valid_i && ready &&
    (ctrl_i.fmt == fpdf_pkg::FMT_HUND || ctrl_i.fmt == fpdf_pkg::FMT_BIN)
    |=> char_q[3] == fpdf_pkg::CH_DOT)
    else $error("decimal point missing in hundredths layout");

  a_dot_thou: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_valid_i && ready &&
    (ctrl_i.fmt == fpdf_pkg::FMT_THOU || ctrl_i.fmt == fpdf_pkg::FMT_SIGNED)
    |=> char_q[2] == fpdf_pkg::CH_DOT)
    else $error("decimal point missing in thousandths layout");

endmodule

### rtl/fixed_point_decimal_formatter.sv
// Top level of the fixed-point decimal formatter: format register and the
// five-stage pipeline. Depends on fpdf_pkg, fpdf_scale, fpdf_split, fpdf_render.
//
//   Channel  Direction  Payload
//   s_axis   in         tdata[31:0] = value
//   m_axis   out        tdata[47:0] = char_0 .. char_5, char_0 lowest
//   cfg      in         cfg_wdata_i[1:0] = format, written when cfg_we_i is high
//
// One item per cycle is taken while m_axis does not stall; each result passes
// through the five register stages in order (scale, round and divide
// estimate, remainder, upper digits, characters).
// Reset clears the valid bits of every stage and sets the format to 0.
// A stall on m_axis holds each full stage in place and backs up to s_axis_tready.
`timescale 1ns / 1ps

module fixed_point_decimal_formatter (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        cfg_we_i,
  input  logic [1:0]  cfg_wdata_i,
  input  logic        s_axis_tvalid,
  output logic        s_axis_tready,
  input  logic [31:0] s_axis_tdata,   // value[31:0]
  output logic        m_axis_tvalid,
  input  logic        m_axis_tready,
  output logic [47:0] m_axis_tdata    // char_0[7:0], char_1 .. char_5[47:40]
);

  fpdf_pkg::fmt_e            format_q;
  logic                      sc_valid, sc_ready;
  logic [fpdf_pkg::NumW-1:0] sc_num;
  logic [7:0]                sc_quot;
  fpdf_pkg::ctrl_t           sc_ctrl;
  logic                      sp_valid, sp_ready;
  logic [3:0]                sp_dig0, sp_dig1, sp_dig2;
  logic [6:0]                sp_rest;
  fpdf_pkg::ctrl_t           sp_ctrl;

  // Format register.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      format_q <= fpdf_pkg::FMT_HUND;
    end else if (cfg_we_i) begin
      format_q <= fpdf_pkg::fmt_e'(cfg_wdata_i);
    end
  end

  fpdf_scale u_scale (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .fmt_i       (format_q),
    .in_valid_i  (s_axis_tvalid),
    .in_ready_o  (s_axis_tready),
    .value_i     (s_axis_tdata),
    .out_valid_o (sc_valid),
    .out_ready_i (sc_ready),
    .num_o       (sc_num),
    .quot_o      (sc_quot),
    .ctrl_o      (sc_ctrl)
  );

  fpdf_split u_split (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (sc_valid),
    .in_ready_o  (sc_ready),
    .num_i       (sc_num),
    .quot_i      (sc_quot),
    .ctrl_i      (sc_ctrl),
    .out_valid_o (sp_valid),
    .out_ready_i (sp_ready),
    .dig0_o      (sp_dig0),
    .dig1_o      (sp_dig1),
    .dig2_o      (sp_dig2),
    .rest_o      (sp_rest),
    .ctrl_o      (sp_ctrl)
  );

  fpdf_render u_render (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (sp_valid),
    .in_ready_o  (sp_ready),
    .dig0_i      (sp_dig0),
    .dig1_i      (sp_dig1),
    .dig2_i      (sp_dig2),
    .rest_i      (sp_rest),
    .ctrl_i      (sp_ctrl),
    .out_valid_o (m_axis_tvalid),
    .out_ready_i (m_axis_tready),
    .chars_o     (m_axis_tdata)
  );

endmodule
